>>> src/ssq_pkg.sv
package ssq_pkg;

   localparam int RING_DEPTH_DEF = 16;
   localparam int CNT_W_DEF      = $clog2(RING_DEPTH_DEF + 1);
   localparam int SEQ_W          = 32;
   localparam int LEN_W          = 16;
   localparam int TAG_W          = 16;

   typedef enum logic [1:0] {
      FUNC_RESTART = 2'd0,
      FUNC_ENQUEUE = 2'd1,
      FUNC_SEGMENT = 2'd2,
      FUNC_DISCARD = 2'd3
   } ssq_func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_WRAP    = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_OUTSIDE = 2'd3
   } ssq_status_type;

   // what the output word is loaded from
   typedef enum logic [1:0] {
      OUT_PLAIN     = 2'd0,
      OUT_PEND_MID  = 2'd1,
      OUT_PEND_LAST = 2'd2
   } ssq_out_type;

   typedef struct packed {
      logic           load;
      logic           restart;
      logic           enqueue;
      logic           set_start;
      logic           scan_init;
      logic           skip;
      logic           take;
      logic           pop;
      logic           out_load;
      ssq_out_type    out_kind;
      ssq_status_type out_status;
   } ssq_cmd_type;

   typedef struct packed {
      ssq_func_type func;
      logic         enq_wrap;
      logic         ring_full;
      logic         range_ok;
      logic         scan_done;
      logic         ent_le_from;
      logic         ent_le_to;
      logic         pend_valid;
      logic         out_last;
   } ssq_stat_type;

   // modulo 2^32 ordering: a before b when the difference is negative
   function automatic logic seq_lt(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return d[SEQ_W-1];
   endfunction

   function automatic logic seq_le(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      return (a == b) || seq_lt(a, b);
   endfunction

endpackage

>>> src/ssq_req_if.sv
interface ssq_req_if;
   logic                        valid;
   logic                        ready;
   ssq_pkg::ssq_func_type       func;
   logic [ssq_pkg::SEQ_W-1:0]   sequence_req;
   logic [ssq_pkg::LEN_W-1:0]   length;
   logic [ssq_pkg::TAG_W-1:0]   message_handle;

   modport source (output valid, output func, output sequence_req, output length,
                   output message_handle, input ready);
   modport sink (input valid, input func, input sequence_req, input length,
                 input message_handle, output ready);
endinterface

>>> src/ssq_rsp_if.sv
interface ssq_rsp_if #(
   parameter int CNT_W = ssq_pkg::CNT_W_DEF
);
   logic                        valid;
   logic                        ready;
   ssq_pkg::ssq_status_type     status;
   logic [ssq_pkg::SEQ_W-1:0]   window_start;
   logic [ssq_pkg::SEQ_W-1:0]   window_end;
   logic                        entry_valid;
   logic [ssq_pkg::SEQ_W-1:0]   entry_end_sequence;
   logic [ssq_pkg::TAG_W-1:0]   entry_handle;
   logic [CNT_W-1:0]            entry_count;
   logic                        last;

   modport source (output valid, output status, output window_start, output window_end,
                   output entry_valid, output entry_end_sequence, output entry_handle,
                   output entry_count, output last, input ready);
   modport sink (input valid, input status, input window_start, input window_end,
                 input entry_valid, input entry_end_sequence, input entry_handle,
                 input entry_count, input last, output ready);
endinterface

>>> src/ssq_ram.sv
module ssq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ssq_datapath.sv
module ssq_datapath #(
   parameter int RING_DEPTH = ssq_pkg::RING_DEPTH_DEF,
   parameter int CNT_W      = $clog2(RING_DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ssq_pkg::ssq_cmd_type      cmd,
   output ssq_pkg::ssq_stat_type     stat,
   input  ssq_pkg::ssq_func_type     req_func,
   input  logic [ssq_pkg::SEQ_W-1:0] req_sequence_req,
   input  logic [ssq_pkg::LEN_W-1:0] req_length,
   input  logic [ssq_pkg::TAG_W-1:0] req_message_handle,
   output ssq_pkg::ssq_status_type   rsp_status,
   output logic [ssq_pkg::SEQ_W-1:0] rsp_window_start,
   output logic [ssq_pkg::SEQ_W-1:0] rsp_window_end,
   output logic                      rsp_entry_valid,
   output logic [ssq_pkg::SEQ_W-1:0] rsp_entry_end_sequence,
   output logic [ssq_pkg::TAG_W-1:0] rsp_entry_handle,
   output logic [CNT_W-1:0]          rsp_entry_count,
   output logic                      rsp_last
);

   localparam int SEQ_W = ssq_pkg::SEQ_W;
   localparam int TAG_W = ssq_pkg::TAG_W;
   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int SUM_W = CNT_W + 1;
   localparam int RAM_W = SEQ_W + TAG_W;

   // latched request
   ssq_pkg::ssq_func_type func_ff, func_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [SEQ_W-1:0] to_ff, to_in;
   logic [SEQ_W-1:0] ne_ff, ne_in;
   logic [TAG_W-1:0] tag_ff, tag_in;

   // window and ring control
   logic [SEQ_W-1:0] start_ff, start_in;
   logic [SEQ_W-1:0] end_ff, end_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] k_ff, k_in;

   // boundary held back until we know whether it is the last one listed
   logic             pend_valid_ff, pend_valid_in;
   logic [SEQ_W-1:0] pend_seq_ff, pend_seq_in;
   logic [TAG_W-1:0] pend_tag_ff, pend_tag_in;

   // output word
   ssq_pkg::ssq_status_type status_ff, status_in;
   logic             ent_valid_ff, ent_valid_in;
   logic [SEQ_W-1:0] eseq_ff, eseq_in;
   logic [TAG_W-1:0] etag_ff, etag_in;
   logic             last_ff, last_in;

   logic [SUM_W-1:0] rd_sum, wr_sum, rd_slot, wr_slot;
   logic [IDX_W-1:0] head_next;
   logic             ram_we;
   logic [RAM_W-1:0] ram_rd_data;
   logic [SEQ_W-1:0] ram_seq;
   logic [TAG_W-1:0] ram_tag;

   always_comb begin
      rd_sum  = SUM_W'(head_ff) + SUM_W'(k_ff);
      wr_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
      rd_slot = (rd_sum >= SUM_W'(RING_DEPTH)) ? rd_sum - SUM_W'(RING_DEPTH) : rd_sum;
      wr_slot = (wr_sum >= SUM_W'(RING_DEPTH)) ? wr_sum - SUM_W'(RING_DEPTH) : wr_sum;
      head_next = (head_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
   end

   assign ram_seq = ram_rd_data[RAM_W-1:TAG_W];
   assign ram_tag = ram_rd_data[TAG_W-1:0];

   ssq_ram #(
      .WIDTH (RAM_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_slot[IDX_W-1:0]),
      .wr_data ({ne_ff, tag_ff}),
      .rd_addr (rd_slot[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      func_in       = func_ff;
      seq_in        = seq_ff;
      to_in         = to_ff;
      ne_in         = ne_ff;
      tag_in        = tag_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      pend_valid_in = pend_valid_ff;
      pend_seq_in   = pend_seq_ff;
      pend_tag_in   = pend_tag_ff;
      status_in     = status_ff;
      ent_valid_in  = ent_valid_ff;
      eseq_in       = eseq_ff;
      etag_in       = etag_ff;
      last_in       = last_ff;
      ram_we        = 1'b0;

      if (cmd.load) begin
         func_in = req_func;
         seq_in  = req_sequence_req;
         to_in   = req_sequence_req + SEQ_W'(req_length);
         ne_in   = end_ff + SEQ_W'(req_length);
         tag_in  = req_message_handle;
      end
      if (cmd.restart) begin
         start_in = seq_ff;
         end_in   = seq_ff;
         head_in  = '0;
         count_in = '0;
      end
      if (cmd.enqueue) begin
         end_in   = ne_ff;
         count_in = count_ff + CNT_W'(1);
         ram_we   = 1'b1;
      end
      if (cmd.set_start) begin
         start_in = seq_ff;
      end
      if (cmd.scan_init) begin
         k_in          = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.skip) begin
         k_in = k_ff + CNT_W'(1);
      end
      if (cmd.take) begin
         pend_valid_in = 1'b1;
         pend_seq_in   = ram_seq;
         pend_tag_in   = ram_tag;
         k_in          = k_ff + CNT_W'(1);
      end
      if (cmd.pop) begin
         head_in  = head_next;
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.out_load) begin
         status_in    = cmd.out_status;
         ent_valid_in = 1'b0;
         eseq_in      = '0;
         etag_in      = '0;
         last_in      = 1'b1;
         case (cmd.out_kind)
            ssq_pkg::OUT_PEND_MID: begin
               ent_valid_in = 1'b1;
               eseq_in      = pend_seq_ff;
               etag_in      = pend_tag_ff;
               last_in      = 1'b0;
            end
            ssq_pkg::OUT_PEND_LAST: begin
               ent_valid_in = 1'b1;
               eseq_in      = pend_seq_ff;
               etag_in      = pend_tag_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= '0;
         end_ff        <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         k_ff          <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         start_ff      <= start_in;
         end_ff        <= end_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         k_ff          <= k_in;
         pend_valid_ff <= pend_valid_in;
      end
      func_ff      <= func_in;
      seq_ff       <= seq_in;
      to_ff        <= to_in;
      ne_ff        <= ne_in;
      tag_ff       <= tag_in;
      pend_seq_ff  <= pend_seq_in;
      pend_tag_ff  <= pend_tag_in;
      status_ff    <= status_in;
      ent_valid_ff <= ent_valid_in;
      eseq_ff      <= eseq_in;
      etag_ff      <= etag_in;
      last_ff      <= last_in;
   end

   always_comb begin
      stat.func        = func_ff;
      stat.enq_wrap    = ssq_pkg::seq_lt(ne_ff, start_ff);
      stat.ring_full   = (count_ff >= CNT_W'(RING_DEPTH));
      stat.range_ok    = ssq_pkg::seq_le(start_ff, seq_ff) &&
                         ((func_ff == ssq_pkg::FUNC_DISCARD) ? ssq_pkg::seq_le(seq_ff, end_ff)
                                                             : ssq_pkg::seq_le(to_ff, end_ff));
      stat.scan_done   = (k_ff == count_ff);
      stat.ent_le_from = ssq_pkg::seq_le(ram_seq, seq_ff);
      stat.ent_le_to   = ssq_pkg::seq_le(ram_seq, to_ff);
      stat.pend_valid  = pend_valid_ff;
      stat.out_last    = last_ff;
   end

   assign rsp_status             = status_ff;
   assign rsp_window_start       = start_ff;
   assign rsp_window_end         = end_ff;
   assign rsp_entry_valid        = ent_valid_ff;
   assign rsp_entry_end_sequence = eseq_ff;
   assign rsp_entry_handle       = etag_ff;
   assign rsp_entry_count        = count_ff;
   assign rsp_last               = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RING_DEPTH))
      else $error("ring fill count above depth");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      cmd.enqueue |-> !stat.ring_full && !stat.enq_wrap)
      else $error("boundary appended to full ring or wrapped window");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> count_ff != '0 ##1 count_ff == $past(count_ff) - CNT_W'(1))
      else $error("pop on empty ring or count not decremented");

   a_mid_needs_pend: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_kind == ssq_pkg::OUT_PEND_MID) |-> pend_valid_ff && cmd.take)
      else $error("non-final entry word without held boundary");

endmodule

>>> src/ssq_ctrl.sv
module ssq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ssq_pkg::ssq_stat_type stat,
   output ssq_pkg::ssq_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_SCAN = 5'b00100,
      ST_TEST = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      finish;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.out_kind   = ssq_pkg::OUT_PLAIN;
      cmd.out_status = ssq_pkg::STATUS_OK;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      finish         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (stat.func)
               ssq_pkg::FUNC_RESTART: begin
                  cmd.restart  = 1'b1;
                  cmd.out_load = 1'b1;
                  state_in     = ST_RESP;
               end
               ssq_pkg::FUNC_ENQUEUE: begin
                  cmd.out_load = 1'b1;
                  if (stat.enq_wrap) begin
                     cmd.out_status = ssq_pkg::STATUS_WRAP;
                  end else if (stat.ring_full) begin
                     cmd.out_status = ssq_pkg::STATUS_FULL;
                  end else begin
                     cmd.enqueue = 1'b1;
                  end
                  state_in = ST_RESP;
               end
               default: begin
                  // segment and discard both walk the ring if the range lies in the window
                  if (!stat.range_ok) begin
                     cmd.out_load   = 1'b1;
                     cmd.out_status = ssq_pkg::STATUS_OUTSIDE;
                     state_in       = ST_RESP;
                  end else begin
                     cmd.set_start = (stat.func == ssq_pkg::FUNC_DISCARD);
                     cmd.scan_init = 1'b1;
                     state_in      = ST_SCAN;
                  end
               end
            endcase
         end
         ST_SCAN: begin
            // ring read address settles here, data is compared next cycle
            if (stat.scan_done) begin
               finish = 1'b1;
            end else begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (stat.func == ssq_pkg::FUNC_DISCARD) begin
               if (stat.ent_le_from) begin
                  cmd.pop  = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  finish = 1'b1;
               end
            end else if (!stat.pend_valid && stat.ent_le_from) begin
               cmd.skip = 1'b1;
               state_in = ST_SCAN;
            end else if (stat.ent_le_to) begin
               cmd.take = 1'b1;
               if (stat.pend_valid) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = ssq_pkg::OUT_PEND_MID;
                  state_in     = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end else begin
               finish = 1'b1;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (stat.out_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         cmd.out_load = 1'b1;
         if (stat.func == ssq_pkg::FUNC_SEGMENT && stat.pend_valid) begin
            cmd.out_kind = ssq_pkg::OUT_PEND_LAST;
         end
         state_in = ST_RESP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_word_per_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("response word without execute cycle");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && stat.out_last) |=> req_ready)
      else $error("final word taken but not ready for next request");

   a_mid_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !stat.out_last) |=> (state_ff == ST_SCAN))
      else $error("non-final word did not resume the ring walk");

endmodule

>>> src/sequence_send_queue_core.sv
// Restart, enqueue and rejected requests present their one word after the execute state.
// Segment and discard walk the ring, each boundary read in a scan state (RAM read) and then
// compared in a test state; a further listed boundary follows once the previous word is taken.
// Throughput: one request at a time; the next is accepted the cycle after the final word goes.
// Reset (synchronous): window start/end, ring head and fill count cleared; ring RAM not cleared.
module sequence_send_queue_core #(
   parameter int RING_DEPTH = ssq_pkg::RING_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ssq_req_if.sink   req_bus,
   ssq_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(RING_DEPTH + 1);

   ssq_pkg::ssq_cmd_type  cmd;
   ssq_pkg::ssq_stat_type stat;

   ssq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssq_datapath #(
      .RING_DEPTH (RING_DEPTH),
      .CNT_W      (CNT_W)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .req_func               (req_bus.func),
      .req_sequence_req       (req_bus.sequence_req),
      .req_length             (req_bus.length),
      .req_message_handle     (req_bus.message_handle),
      .rsp_status             (rsp_bus.status),
      .rsp_window_start       (rsp_bus.window_start),
      .rsp_window_end         (rsp_bus.window_end),
      .rsp_entry_valid        (rsp_bus.entry_valid),
      .rsp_entry_end_sequence (rsp_bus.entry_end_sequence),
      .rsp_entry_handle       (rsp_bus.entry_handle),
      .rsp_entry_count        (rsp_bus.entry_count),
      .rsp_last               (rsp_bus.last)
   );

endmodule
